// File: hw/rtl/mafs_pkg.sv
// Shared widths, codes, rate tables and record types of the MPEG audio frame sync unit.
package mafs_pkg;

	localparam int BYTE_W  = 8;
	localparam int LEN_W   = 15;
	localparam int CNT_W   = 16;
	localparam int VER_W   = 2;
	localparam int LAY_W   = 2;
	localparam int KBPS_W  = 9;
	localparam int SR_W    = 16;
	localparam int COEF_W  = 18;
	localparam int NUM_W   = 27;
	localparam int QUO_W   = 12;
	localparam int WIN_W   = 24;
	localparam int SEQ_W   = 32;

	localparam logic [LEN_W-1:0] MAX_FRAME_RESET = 15'd16384;
	localparam logic [LEN_W-1:0] MIN_FRAME_LEN   = 15'd4;
	localparam logic [CNT_W-1:0] GARB_SAT        = 16'hFFFF;

	// Header field codes
	localparam logic [7:0] SYNC_BYTE     = 8'hFF;
	localparam logic [7:0] SYNC_MASK     = 8'hE0;
	localparam logic [1:0] VBITS_MPEG1   = 2'b11;
	localparam logic [1:0] VBITS_MPEG2   = 2'b10;
	localparam logic [1:0] VBITS_RSV     = 2'b01;
	localparam logic [1:0] LBITS_RSV     = 2'b00;
	localparam logic [3:0] BRI_FREE      = 4'd0;
	localparam logic [3:0] BRI_BAD       = 4'd15;
	localparam logic [1:0] SRI_RSV       = 2'd3;

	localparam logic [VER_W-1:0] VER_MPEG1  = 2'd0;
	localparam logic [VER_W-1:0] VER_MPEG2  = 2'd1;
	localparam logic [VER_W-1:0] VER_MPEG25 = 2'd2;
	localparam logic [LAY_W-1:0] LAYER_I    = 2'd1;
	localparam logic [LAY_W-1:0] LAYER_II   = 2'd2;
	localparam logic [LAY_W-1:0] LAYER_III  = 2'd3;

	// Bitrate tables in kbps, indexed by the bitrate field
	localparam logic [KBPS_W-1:0] RATE_V1_L1 [0:15] = '{
		9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
		9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
	localparam logic [KBPS_W-1:0] RATE_V1_L2 [0:15] = '{
		9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
		9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
	localparam logic [KBPS_W-1:0] RATE_V1_L3 [0:15] = '{
		9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
		9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
	localparam logic [KBPS_W-1:0] RATE_V2_L1 [0:15] = '{
		9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
		9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
	localparam logic [KBPS_W-1:0] RATE_V2_L23 [0:15] = '{
		9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
		9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};

	// State record kept in the state memory
	typedef struct packed {
		logic [WIN_W-1:0] win;
		logic [1:0]       fill;
		logic [LEN_W-1:0] remain;
		logic [CNT_W-1:0] garb;
	} mafs_state_t;

	// Status from the header length unit
	typedef struct packed {
		logic             done;
		logic             valid;
		logic [LEN_W-1:0] len;
		logic [VER_W-1:0] ver;
		logic [LAY_W-1:0] lay;
	} mafs_hdr_res_t;

	// One result beat
	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              in_frame;
		logic              frame_start;
		logic              frame_end;
		logic [LEN_W-1:0]  frame_length;
		logic [CNT_W-1:0]  skipped_count;
		logic [VER_W-1:0]  mpeg_version;
		logic [LAY_W-1:0]  layer_number;
		logic              run_last;
	} mafs_result_t;

	function automatic logic [KBPS_W-1:0] kbps_lookup(input logic [VER_W-1:0] ver,
		input logic [LAY_W-1:0] lay, input logic [3:0] bri);
		logic [KBPS_W-1:0] r;
		if (ver == VER_MPEG1) begin
			case (lay)
				LAYER_I:  r = RATE_V1_L1[bri];
				LAYER_II: r = RATE_V1_L2[bri];
				default:  r = RATE_V1_L3[bri];
			endcase
		end else if (lay == LAYER_I) begin
			r = RATE_V2_L1[bri];
		end else begin
			r = RATE_V2_L23[bri];
		end
		return r;
	endfunction

	function automatic logic [SR_W-1:0] srate_lookup(input logic [VER_W-1:0] ver,
		input logic [1:0] sri);
		logic [SR_W-1:0] base;
		case (sri)
			2'd0:    base = 16'd44100;
			2'd1:    base = 16'd48000;
			default: base = 16'd32000;
		endcase
		case (ver)
			VER_MPEG1: return base;
			VER_MPEG2: return base >> 1;
			default:   return base >> 2;
		endcase
	endfunction

	// Slot coefficient times 1000, so that kbps times this gives the numerator
	function automatic logic [COEF_W-1:0] coef_lookup(input logic [VER_W-1:0] ver,
		input logic [LAY_W-1:0] lay);
		logic [COEF_W-1:0] r;
		if (lay == LAYER_I)
			r = 18'd12000;
		else if (lay == LAYER_II || ver == VER_MPEG1)
			r = 18'd144000;
		else
			r = 18'd72000;
		return r;
	endfunction

endpackage

// File: hw/rtl/mafs_if.sv
// Channel interfaces of the MPEG audio frame sync unit: byte input, result output, config.
interface mafs_in_if import mafs_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] in_byte;
	logic              end_of_stream;

	modport source (output valid, in_byte, end_of_stream, input ready);
	modport sink (input valid, in_byte, end_of_stream, output ready);
endinterface

interface mafs_out_if import mafs_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              in_frame;
	logic              frame_start;
	logic              frame_end;
	logic [LEN_W-1:0]  frame_length;
	logic [CNT_W-1:0]  skipped_count;
	logic [VER_W-1:0]  mpeg_version;
	logic [LAY_W-1:0]  layer_number;
	logic              run_last;

	modport source (output valid, out_byte, in_frame, frame_start, frame_end, frame_length,
		skipped_count, mpeg_version, layer_number, run_last, input ready);
	modport sink (input valid, out_byte, in_frame, frame_start, frame_end, frame_length,
		skipped_count, mpeg_version, layer_number, run_last, output ready);
endinterface

interface mafs_cfg_if import mafs_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [LEN_W-1:0] max_frame_bytes;

	modport source (output valid, max_frame_bytes, input ready);
	modport sink (input valid, max_frame_bytes, output ready);
endinterface

// File: hw/rtl/mafs_hdr.sv
// Header check and frame length unit: table lookup, one multiply, 12-step restoring divide.
module mafs_hdr import mafs_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [WIN_W-1:0]    hdr,
	input  logic [LEN_W-1:0]    max_len,
	output mafs_hdr_res_t       res
);

	typedef enum logic [1:0] {H_IDLE, H_MUL, H_DIV, H_FIN} hstate_t;

	hstate_t             hst_q;
	logic                done_q;
	logic                valid_q;
	logic [LEN_W-1:0]    len_q;
	logic [VER_W-1:0]    ver_q;
	logic [LAY_W-1:0]    lay_q;
	logic                pad_q;
	logic [KBPS_W-1:0]   kbps_q;
	logic [COEF_W-1:0]   coef_q;
	logic [SR_W-1:0]     sr_q;
	logic [NUM_W-1:0]    num_q;
	logic [NUM_W-1:0]    dvs_q;
	logic [QUO_W-1:0]    quo_q;
	logic [3:0]          cnt_q;

	logic [7:0]          h0, h1, h2;
	logic [1:0]          vbits, lbits, sri;
	logic [3:0]          bri;
	logic                pre_ok;
	logic [VER_W-1:0]    ver_d;
	logic [LAY_W-1:0]    lay_d;
	logic [QUO_W:0]      base_len;
	logic [LEN_W-1:0]    len_c;

	// Split the header into its fields
	assign h0    = hdr[23:16];
	assign h1    = hdr[15:8];
	assign h2    = hdr[7:0];
	assign vbits = h1[4:3];
	assign lbits = h1[2:1];
	assign bri   = h2[7:4];
	assign sri   = h2[3:2];

	assign pre_ok = (h0 == SYNC_BYTE) && ((h1 & SYNC_MASK) == SYNC_MASK)
		&& (vbits != VBITS_RSV) && (lbits != LBITS_RSV)
		&& (bri != BRI_FREE) && (bri != BRI_BAD) && (sri != SRI_RSV);

	always_comb begin
		case (vbits)
			VBITS_MPEG1: ver_d = VER_MPEG1;
			VBITS_MPEG2: ver_d = VER_MPEG2;
			default:     ver_d = VER_MPEG25;
		endcase
		lay_d = LAY_W'(3'd4 - {1'b0, lbits});
	end

	// Add padding and scale layer I slots to bytes
	assign base_len = {1'b0, quo_q} + (QUO_W+1)'(pad_q);
	assign len_c    = (lay_q == LAYER_I) ? {base_len, 2'b00} : {1'b0, 1'b0, base_len};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hst_q   <= H_IDLE;
			done_q  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (hst_q)
				H_IDLE: begin
					if (start) begin
						if (pre_ok) begin
							hst_q <= H_MUL;
						end else begin
							valid_q <= 1'b0;
							done_q  <= 1'b1;
						end
					end
				end
				H_MUL: begin
					hst_q <= H_DIV;
				end
				H_DIV: begin
					if (cnt_q == 4'd0)
						hst_q <= H_FIN;
				end
				H_FIN: begin
					valid_q <= (len_c >= MIN_FRAME_LEN) && (len_c <= max_len);
					done_q  <= 1'b1;
					hst_q   <= H_IDLE;
				end
				default: hst_q <= H_IDLE;
			endcase
		end
	end

	// Datapath: latch lookups, multiply, then one quotient bit a cycle
	always_ff @(posedge clk) begin
		case (hst_q)
			H_IDLE: begin
				kbps_q <= kbps_lookup(ver_d, lay_d, bri);
				coef_q <= coef_lookup(ver_d, lay_d);
				sr_q   <= srate_lookup(ver_d, sri);
				ver_q  <= ver_d;
				lay_q  <= lay_d;
				pad_q  <= h2[1];
			end
			H_MUL: begin
				num_q <= NUM_W'(kbps_q) * NUM_W'(coef_q);
				dvs_q <= {sr_q, {(QUO_W-1){1'b0}}};
				quo_q <= '0;
				cnt_q <= 4'(QUO_W - 1);
			end
			H_DIV: begin
				if (num_q >= dvs_q) begin
					num_q <= num_q - dvs_q;
					quo_q <= {quo_q[QUO_W-2:0], 1'b1};
				end else begin
					quo_q <= {quo_q[QUO_W-2:0], 1'b0};
				end
				dvs_q <= dvs_q >> 1;
				cnt_q <= cnt_q - 4'd1;
			end
			H_FIN: begin
				len_q <= len_c;
			end
			default: ;
		endcase
	end

	assign res.done  = done_q;
	assign res.valid = valid_q;
	assign res.len   = len_q;
	assign res.ver   = ver_q;
	assign res.lay   = lay_q;

endmodule

// File: hw/rtl/mpeg_audio_frame_sync_unit.sv
// Top level of the MPEG audio frame sync unit: state memory, byte sequencer, result register.
//
//  channel  dir  beat contents                                   accepted when
//  stream   in   in_byte, end_of_stream                          valid && ready
//  result   out  out_byte, frame tags, length, skip count, ...   valid && ready
//  cfg      in   max_frame_bytes                                 valid && ready (ready tied 1)
//
// Each byte passes S_IDLE, S_LOAD and S_WB; with a full window it also passes S_CHECK,
// and a header test adds S_HWAIT, where mafs_hdr runs its 12-step divide if the fields
// pass, and S_HEMIT. End of stream adds an S_CHECK pass per drained byte. Window, fill,
// frame and skip counts live in a one-entry synchronous RAM, read on accept, written
// back last; reset needs no clearing pass. A waiting result beat does not block the next
// byte, but a stalled result side holds the sequencer before its next beat.
module mpeg_audio_frame_sync_unit import mafs_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	mafs_in_if.sink         stream,
	mafs_out_if.source      result,
	mafs_cfg_if.sink        cfg
);

	typedef enum logic [2:0] {S_IDLE, S_LOAD, S_CHECK, S_HWAIT, S_HEMIT, S_WB} state_t;

	state_t              state_q;
	logic [LEN_W-1:0]    max_q;
	logic [BYTE_W-1:0]   byte_q;
	logic                eos_q;
	logic [WIN_W-1:0]    win_q;
	logic [1:0]          fill_q;
	logic [LEN_W-1:0]    rem_q;
	logic [CNT_W-1:0]    garb_q;
	logic [SEQ_W-1:0]    seq_q;
	logic [1:0]          k_q;
	logic [1:0]          last_q;
	logic                out_valid_q;
	mafs_result_t        out_q;

	mafs_state_t         st_mem [0:0];
	mafs_state_t         rd_s1;
	logic                mem_vld_q;
	logic                rd_en;
	logic                wr_en;
	mafs_state_t         wr_data;
	mafs_state_t         cur_st;
	logic [SEQ_W-1:0]    cat;
	logic [SEQ_W-1:0]    seq_d;

	logic                slot_free;
	logic                can_test;
	logic                hdr_start;
	logic                emit_en;
	mafs_result_t        res_d;
	logic [LEN_W-1:0]    rem_d;
	logic [CNT_W-1:0]    garb_d;
	mafs_hdr_res_t       hres;

	// Config register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			max_q <= MAX_FRAME_RESET;
		else if (cfg.valid)
			max_q <= cfg.max_frame_bytes;
	end

	// State memory: read on accept, write back at the end of the byte
	assign stream.ready = (state_q == S_IDLE);
	assign rd_en        = stream.valid && (state_q == S_IDLE);
	assign wr_en        = (state_q == S_WB);

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_s1 <= st_mem[0];
		if (wr_en)
			st_mem[0] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mem_vld_q <= 1'b0;
		else if (wr_en)
			mem_vld_q <= 1'b1;
	end

	assign cur_st = mem_vld_q ? rd_s1 : '0;

	// Build the write-back record
	always_comb begin
		wr_data = '0;
		if (!eos_q) begin
			wr_data.remain = rem_q;
			wr_data.garb   = garb_q;
			if (fill_q != 2'd3) begin
				wr_data.win  = {win_q[15:0], byte_q};
				wr_data.fill = fill_q + 2'd1;
			end else begin
				wr_data.win  = seq_q[SEQ_W-1:BYTE_W];
				wr_data.fill = 2'd3;
			end
		end
	end

	// Left-align the held bytes and the new byte, oldest on top
	assign cat = {cur_st.win, byte_q};

	always_comb begin
		case (cur_st.fill)
			2'd3:    seq_d = cat;
			2'd2:    seq_d = cat << 8;
			2'd1:    seq_d = cat << 16;
			default: seq_d = cat << 24;
		endcase
	end

	// Header length unit
	assign can_test  = (k_q == 2'd0) && (fill_q == 2'd3);
	assign hdr_start = (state_q == S_CHECK) && (rem_q == '0) && can_test;

	mafs_hdr u_hdr (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (hdr_start),
		.hdr     (seq_q[SEQ_W-1:BYTE_W]),
		.max_len (max_q),
		.res     (hres)
	);

	// Tag the byte on top of the sequence and update the counts
	assign slot_free = !out_valid_q || result.ready;
	assign emit_en   = slot_free
		&& (((state_q == S_CHECK) && !hdr_start) || (state_q == S_HEMIT));

	always_comb begin
		res_d          = '0;
		res_d.out_byte = seq_q[SEQ_W-1:SEQ_W-BYTE_W];
		res_d.run_last = (k_q == last_q);
		rem_d          = rem_q;
		garb_d         = garb_q;
		if ((state_q == S_HEMIT) && hres.valid) begin
			res_d.in_frame      = 1'b1;
			res_d.frame_start   = 1'b1;
			res_d.frame_length  = hres.len;
			res_d.skipped_count = garb_q;
			res_d.mpeg_version  = hres.ver;
			res_d.layer_number  = hres.lay;
			rem_d               = hres.len - LEN_W'(1);
			res_d.frame_end     = (rem_d == '0);
			garb_d              = '0;
		end else if (rem_q != '0) begin
			res_d.in_frame  = 1'b1;
			rem_d           = rem_q - LEN_W'(1);
			res_d.frame_end = (rem_q == LEN_W'(1));
		end else if (garb_q != GARB_SAT) begin
			garb_d = garb_q + CNT_W'(1);
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			k_q         <= 2'd0;
			last_q      <= 2'd0;
			eos_q       <= 1'b0;
			fill_q      <= 2'd0;
		end else begin
			if (emit_en)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (stream.valid) begin
						eos_q   <= stream.end_of_stream;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					fill_q <= cur_st.fill;
					k_q    <= 2'd0;
					last_q <= eos_q ? cur_st.fill : 2'd0;
					if (!eos_q && (cur_st.fill != 2'd3))
						state_q <= S_WB;
					else
						state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (hdr_start) begin
						state_q <= S_HWAIT;
					end else if (emit_en) begin
						k_q     <= k_q + 2'd1;
						state_q <= (k_q == last_q) ? S_WB : S_CHECK;
					end
				end
				S_HWAIT: begin
					if (hres.done)
						state_q <= S_HEMIT;
				end
				S_HEMIT: begin
					if (emit_en) begin
						k_q     <= k_q + 2'd1;
						state_q <= (k_q == last_q) ? S_WB : S_CHECK;
					end
				end
				S_WB: begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Working copies of the record and the result payload
	always_ff @(posedge clk) begin
		if (rd_en)
			byte_q <= stream.in_byte;
		if (state_q == S_LOAD) begin
			win_q  <= cur_st.win;
			rem_q  <= cur_st.remain;
			garb_q <= cur_st.garb;
			seq_q  <= seq_d;
		end else if (emit_en) begin
			rem_q  <= rem_d;
			garb_q <= garb_d;
			seq_q  <= seq_q << BYTE_W;
		end
		if (emit_en)
			out_q <= res_d;
	end

	assign result.valid         = out_valid_q;
	assign result.out_byte      = out_q.out_byte;
	assign result.in_frame      = out_q.in_frame;
	assign result.frame_start   = out_q.frame_start;
	assign result.frame_end     = out_q.frame_end;
	assign result.frame_length  = out_q.frame_length;
	assign result.skipped_count = out_q.skipped_count;
	assign result.mpeg_version  = out_q.mpeg_version;
	assign result.layer_number  = out_q.layer_number;
	assign result.run_last      = out_q.run_last;

endmodule

// File: verif/tb_mpeg_audio_frame_sync_unit.sv
// Testbench for the MPEG audio frame sync unit: directed and random byte streams checked beat by beat.
`timescale 1ns / 1ps

module tb_mpeg_audio_frame_sync_unit;
	import mafs_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 64;
	localparam int MAX_PRINTS    = 100;
	localparam int IDLE_PCT      = 6;

	// Header field codes not named in the package
	localparam logic [1:0] VBITS_MPEG25 = 2'b00;
	localparam logic [1:0] LBITS_L1     = 2'b11;
	localparam logic [1:0] LBITS_L2     = 2'b10;
	localparam logic [1:0] LBITS_L3     = 2'b01;

	logic clk;
	logic arst_n;

	mafs_in_if  stream_if ();
	mafs_out_if result_if ();
	mafs_cfg_if cfg_if ();

	mpeg_audio_frame_sync_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream_if),
		.result (result_if),
		.cfg    (cfg_if)
	);

	// Bitrate tables in kbps and base sample rates in Hz
	int unsigned mpeg1_kbps [0:2][0:15] = '{
		'{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0},
		'{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0},
		'{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0}};
	int unsigned lsf_l1_kbps [0:15] =
		'{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0};
	int unsigned lsf_l23_kbps [0:15] =
		'{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0};
	int unsigned base_hz [0:2] = '{44100, 48000, 32000};

	// Predictor state
	logic [WIN_W-1:0] held_bytes;
	int unsigned      held_count;
	int unsigned      frame_left;
	int unsigned      skip_run;
	int unsigned      max_len_limit;

	mafs_result_t pending_tags [$];

	int  mismatch_count;
	int  cycle_count;
	int  beat_count;
	int  bytes_sent;
	bit  gaps_on;

	// Clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Abort a run that hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Stall the result side at random
	always @(negedge clk) begin
		result_if.ready <= !(gaps_on && ($urandom_range(0, 99) < IDLE_PCT));
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		if (mismatch_count < MAX_PRINTS)
			$display("mismatch at beat %0d: %s got %0d want %0d", beat_count, what, got, want);
		mismatch_count++;
	endtask

	// Raw frame length of a four-byte header, 0 if the header is malformed
	function automatic int unsigned frame_bytes(input logic [31:0] h,
		output logic [VER_W-1:0] ver, output logic [LAY_W-1:0] lay);
		logic [1:0]  vb;
		logic [1:0]  lb;
		logic [1:0]  sri;
		logic [3:0]  bri;
		int unsigned kbps;
		int unsigned hz;
		int unsigned bps;
		vb  = h[20:19];
		lb  = h[18:17];
		bri = h[15:12];
		sri = h[11:10];
		ver = VER_MPEG1;
		lay = LAYER_I;
		if (h[31:24] != SYNC_BYTE || (h[23:16] & SYNC_MASK) != SYNC_MASK)
			return 0;
		if (vb == VBITS_RSV || lb == LBITS_RSV || bri == BRI_FREE || bri == BRI_BAD ||
			sri == SRI_RSV)
			return 0;
		ver = (vb == VBITS_MPEG1) ? VER_MPEG1 : (vb == VBITS_MPEG2) ? VER_MPEG2 : VER_MPEG25;
		case (lb)
			LBITS_L1: lay = LAYER_I;
			LBITS_L2: lay = LAYER_II;
			default:  lay = LAYER_III;
		endcase
		if (ver == VER_MPEG1)
			kbps = mpeg1_kbps[int'(lay) - 1][bri];
		else if (lay == LAYER_I)
			kbps = lsf_l1_kbps[bri];
		else
			kbps = lsf_l23_kbps[bri];
		// MPEG-2 halves and MPEG-2.5 quarters the base rate
		hz  = base_hz[sri] >> ver;
		bps = kbps * 1000;
		if (lay == LAYER_I)
			return (12 * bps / hz + h[9]) * 4;
		if (lay == LAYER_II || ver == VER_MPEG1)
			return 144 * bps / hz + h[9];
		return 72 * bps / hz + h[9];
	endfunction

	// Tag one byte leaving the window and advance the frame and skip state
	function automatic mafs_result_t tag_byte(input logic [7:0] b, input logic [31:0] hdr,
		input bit can_test);
		mafs_result_t     r;
		logic [VER_W-1:0] ver;
		logic [LAY_W-1:0] lay;
		int unsigned      n;
		r = '0;
		r.out_byte = b;
		n = frame_bytes(hdr, ver, lay);
		if (frame_left != 0) begin
			frame_left--;
			r.in_frame  = 1'b1;
			r.frame_end = (frame_left == 0);
		end else if (can_test && n >= MIN_FRAME_LEN && n <= max_len_limit) begin
			r.in_frame      = 1'b1;
			r.frame_start   = 1'b1;
			r.frame_length  = LEN_W'(n);
			r.skipped_count = CNT_W'(skip_run);
			r.mpeg_version  = ver;
			r.layer_number  = lay;
			frame_left      = n - 1;
			r.frame_end     = (frame_left == 0);
			skip_run        = 0;
		end else if (skip_run < GARB_SAT) begin
			skip_run++;
		end
		return r;
	endfunction

	// Work out the beats caused by one accepted byte
	task automatic predict_byte(input logic [7:0] b, input bit eos);
		logic [7:0]   seq [0:3];
		logic [31:0]  hdr;
		int unsigned  total;
		mafs_result_t r;
		seq = '{default: 8'h00};
		for (int k = 0; k < held_count; k++)
			seq[k] = 8'(held_bytes >> (8 * (held_count - 1 - k)));
		seq[held_count] = b;
		total = held_count + 1;
		hdr = {seq[0], seq[1], seq[2], seq[3]};
		if (!eos) begin
			if (total == 4) begin
				r = tag_byte(seq[0], hdr, 1'b1);
				r.run_last = 1'b1;
				pending_tags.push_back(r);
				held_bytes = {seq[1], seq[2], seq[3]};
				held_count = 3;
			end else begin
				held_bytes = {held_bytes[15:0], b};
				held_count = total;
			end
		end else begin
			// Drain the window; only a full window position gets a header test
			for (int k = 0; k < total; k++) begin
				r = tag_byte(seq[k], hdr, (k == 0 && total == 4));
				r.run_last = (k == total - 1);
				pending_tags.push_back(r);
			end
			held_bytes = '0;
			held_count = 0;
			frame_left = 0;
			skip_run   = 0;
		end
	endtask

	// Compare each result beat with the oldest expectation
	always @(posedge clk) begin : check_beats
		mafs_result_t got;
		mafs_result_t want;
		if (arst_n && result_if.valid && result_if.ready) begin
			got.out_byte      = result_if.out_byte;
			got.in_frame      = result_if.in_frame;
			got.frame_start   = result_if.frame_start;
			got.frame_end     = result_if.frame_end;
			got.frame_length  = result_if.frame_length;
			got.skipped_count = result_if.skipped_count;
			got.mpeg_version  = result_if.mpeg_version;
			got.layer_number  = result_if.layer_number;
			got.run_last      = result_if.run_last;
			if (pending_tags.size() == 0) begin
				report_mismatch("unexpected beat, out_byte", got.out_byte, 0);
			end else begin
				want = pending_tags.pop_front();
				if (got.out_byte !== want.out_byte)
					report_mismatch("out_byte", got.out_byte, want.out_byte);
				if (got.in_frame !== want.in_frame)
					report_mismatch("in_frame", got.in_frame, want.in_frame);
				if (got.frame_start !== want.frame_start)
					report_mismatch("frame_start", got.frame_start, want.frame_start);
				if (got.frame_end !== want.frame_end)
					report_mismatch("frame_end", got.frame_end, want.frame_end);
				if (got.frame_length !== want.frame_length)
					report_mismatch("frame_length", got.frame_length, want.frame_length);
				if (got.skipped_count !== want.skipped_count)
					report_mismatch("skipped_count", got.skipped_count, want.skipped_count);
				if (got.mpeg_version !== want.mpeg_version)
					report_mismatch("mpeg_version", got.mpeg_version, want.mpeg_version);
				if (got.layer_number !== want.layer_number)
					report_mismatch("layer_number", got.layer_number, want.layer_number);
				if (got.run_last !== want.run_last)
					report_mismatch("run_last", got.run_last, want.run_last);
			end
			beat_count++;
		end
	end

	// Send one byte beat; call at a falling edge, returns at a falling edge
	task automatic send_byte(input logic [7:0] b, input bit eos);
		while (gaps_on && ($urandom_range(0, 99) < IDLE_PCT)) begin
			stream_if.valid <= 1'b0;
			@(negedge clk);
		end
		stream_if.valid         <= 1'b1;
		stream_if.in_byte       <= b;
		stream_if.end_of_stream <= eos;
		do
			@(posedge clk);
		while (!stream_if.ready);
		predict_byte(b, eos);
		bytes_sent++;
		@(negedge clk);
	endtask

	// Drop valid, wait for every expected beat, then let the block settle
	task automatic wait_idle();
		stream_if.valid <= 1'b0;
		while (pending_tags.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_max_len(input logic [LEN_W-1:0] v);
		cfg_if.valid           <= 1'b1;
		cfg_if.max_frame_bytes <= v;
		do
			@(posedge clk);
		while (!cfg_if.ready);
		max_len_limit = v;
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	function automatic logic [31:0] make_header(input logic [1:0] vb, input logic [1:0] lb,
		input logic [3:0] bri, input logic [1:0] sri, input bit pad);
		logic [7:0] b1;
		logic [7:0] b2;
		b1 = {3'b111, vb, lb, 1'($urandom_range(0, 1))};
		b2 = {bri, sri, pad, 1'($urandom_range(0, 1))};
		return {SYNC_BYTE, b1, b2, 8'($urandom_range(0, 255))};
	endfunction

	// Mostly short low-rate frames, sometimes any valid field mix
	function automatic logic [31:0] random_header();
		logic [1:0] vb;
		logic [1:0] lb;
		if ($urandom_range(0, 3) != 0) begin
			vb = ($urandom_range(0, 3) == 0) ? VBITS_MPEG25 : VBITS_MPEG2;
			lb = ($urandom_range(0, 2) == 0) ? LBITS_L2 : LBITS_L3;
			return make_header(vb, lb, 4'($urandom_range(1, 3)), 2'($urandom_range(0, 2)),
				1'($urandom_range(0, 1)));
		end
		case ($urandom_range(0, 2))
			0:       vb = VBITS_MPEG1;
			1:       vb = VBITS_MPEG2;
			default: vb = VBITS_MPEG25;
		endcase
		case ($urandom_range(0, 2))
			0:       lb = LBITS_L1;
			1:       lb = LBITS_L2;
			default: lb = LBITS_L3;
		endcase
		return make_header(vb, lb, 4'($urandom_range(1, 14)), 2'($urandom_range(0, 2)),
			1'($urandom_range(0, 1)));
	endfunction

	task automatic send_word(input logic [31:0] w, input bit eos_last);
		for (int k = 3; k >= 0; k--)
			send_byte(w[8*k +: 8], eos_last && k == 0);
	endtask

	// One random phase under a given length limit, closed by an end of stream
	task automatic run_stream_phase(input logic [LEN_W-1:0] limit, input int n_bytes);
		int          start;
		int          left;
		int unsigned pick;
		int unsigned body_n;
		int unsigned n;
		logic [31:0] hdr;
		logic [VER_W-1:0] ver;
		logic [LAY_W-1:0] lay;
		write_max_len(limit);
		start = bytes_sent;
		while (bytes_sent - start < n_bytes) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				// Well-formed frame: header and body, long bodies cut short
				hdr = random_header();
				n = frame_bytes(hdr, ver, lay);
				body_n = n - 4;
				if (body_n > 120)
					body_n = $urandom_range(0, 120);
				// Keep the phase close to its byte budget
				left = n_bytes - (bytes_sent - start) - 4;
				if (left < 0)
					left = 0;
				if (body_n > unsigned'(left))
					body_n = unsigned'(left);
				send_word(hdr, 1'b0);
				for (int i = 0; i < body_n; i++)
					send_byte(($urandom_range(0, 15) == 0) ? SYNC_BYTE :
						8'($urandom_range(0, 255)), 1'b0);
			end else if (pick < 67) begin
				// Broken header: corrupt one field of a good one
				hdr = random_header();
				case ($urandom_range(0, 6))
					0:       hdr[31:24] = 8'($urandom_range(0, 254));
					1:       hdr[23:21] = 3'($urandom_range(0, 6));
					2:       hdr[20:19] = VBITS_RSV;
					3:       hdr[18:17] = LBITS_RSV;
					4:       hdr[15:12] = BRI_FREE;
					5:       hdr[15:12] = BRI_BAD;
					default: hdr[11:10] = SRI_RSV;
				endcase
				send_word(hdr, 1'b0);
			end else if (pick < 87) begin
				// Garbage run with stray sync bytes
				repeat ($urandom_range(1, 10))
					send_byte(($urandom_range(0, 3) == 0) ? SYNC_BYTE :
						8'($urandom_range(0, 255)), 1'b0);
			end else if (pick < 92) begin
				send_byte(8'($urandom_range(0, 255)), 1'b1);
			end else begin
				send_byte(8'($urandom_range(0, 255)), 1'b0);
			end
		end
		send_byte(8'($urandom_range(0, 255)), 1'b1);
		wait_idle();
	endtask

	// End of stream with fewer than three bytes held
	task automatic test_partial_drain();
		send_byte(8'hFF, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFB, 1'b0);
		send_byte(8'h00, 1'b1);
		wait_idle();
	endtask

	// One header of each version and layer, and a reserved version, each cut by end of stream
	task automatic test_header_kinds();
		send_word(make_header(VBITS_MPEG1, LBITS_L1, 4'd1, 2'd0, 1'b0), 1'b1);
		send_word(make_header(VBITS_MPEG2, LBITS_L2, 4'd14, 2'd2, 1'b1), 1'b1);
		send_word(make_header(VBITS_MPEG25, LBITS_L3, 4'd1, 2'd1, 1'b0), 1'b1);
		send_word(make_header(VBITS_RSV, LBITS_L3, 4'd5, 2'd0, 1'b0), 1'b1);
		wait_idle();
	endtask

	// Long stretch with both sides streaming at full rate
	task automatic test_long_run_no_gaps();
		gaps_on = 1'b0;
		run_stream_phase(MAX_FRAME_RESET, 110);
		gaps_on = 1'b1;
	endtask

	// Limits at and below the shortest legal length
	task automatic test_small_limits();
		run_stream_phase(15'd3, 20);
		run_stream_phase(MIN_FRAME_LEN, 20);
		run_stream_phase(15'd0, 15);
	endtask

	// Limits around the longest possible frame and a short one
	task automatic test_limit_boundaries();
		run_stream_phase(15'd2881, 50);
		run_stream_phase(15'd2880, 40);
		run_stream_phase(15'd60, 50);
		run_stream_phase(LEN_W'($urandom_range(4, 16384)), 50);
	endtask

	task automatic test_full_width_limit();
		run_stream_phase(15'h7FFF, 50);
	endtask

	initial begin
		arst_n                  = 1'b0;
		gaps_on                 = 1'b1;
		mismatch_count          = 0;
		cycle_count             = 0;
		beat_count              = 0;
		bytes_sent              = 0;
		held_bytes              = '0;
		held_count              = 0;
		frame_left              = 0;
		skip_run                = 0;
		max_len_limit           = MAX_FRAME_RESET;
		stream_if.valid         = 1'b0;
		stream_if.in_byte       = '0;
		stream_if.end_of_stream = 1'b0;
		result_if.ready         = 1'b0;
		cfg_if.valid            = 1'b0;
		cfg_if.max_frame_bytes  = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_partial_drain();
		test_header_kinds();
		test_long_run_no_gaps();
		test_small_limits();
		test_limit_boundaries();
		test_full_width_limit();

		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: mpeg_audio_frame_sync_unit.f
hw/rtl/mafs_pkg.sv
hw/rtl/mafs_if.sv
hw/rtl/mafs_hdr.sv
hw/rtl/mpeg_audio_frame_sync_unit.sv
verif/tb_mpeg_audio_frame_sync_unit.sv
